@@ rtl/mersenne_twister_generator_core_assert.svh @@
// assertion macros for the mersenne twister generator core
// used by modules that declare clk and rst_n; no other dependencies
`ifndef MERSENNE_TWISTER_GENERATOR_CORE_ASSERT_SVH
`define MERSENNE_TWISTER_GENERATOR_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MTG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define MTG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mtg_pkg.sv @@
// shared types and constants for the mersenne twister generator core
// no dependencies
`default_nettype none

package mtg_pkg;

  localparam int unsigned TBL_LEN = 624;
  localparam int unsigned TBL_MID = 397;
  localparam int unsigned AW      = 10;
  localparam int unsigned WW      = 32;

  localparam logic [WW-1:0] TWIST_XOR  = 32'h9908_B0DF;
  localparam logic [WW-1:0] TEMPER_B   = 32'h9D2C_5680;
  localparam logic [WW-1:0] TEMPER_C   = 32'hEFC6_0000;
  localparam logic [WW-1:0] FILL_MULT  = 32'd69069;
  localparam logic [WW-1:0] UPPER_MASK = 32'h8000_0000;
  localparam logic [WW-1:0] LOWER_MASK = 32'h7FFF_FFFF;
  localparam logic [WW-1:0] SEED_RESET = 32'd4357;

  typedef logic [AW-1:0] addr_t;
  typedef logic [WW-1:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_TW_START,
    ST_TW_C0,
    ST_TW_RM,
    ST_TW_WR,
    ST_DRAW_RD,
    ST_DRAW_LAT
  } state_t;

  // table port request from the sequencer
  typedef struct packed {
    logic  we;
    addr_t waddr;
    word_t wdata;
    logic  re;
    addr_t raddr;
  } ram_req_t;

endpackage

`default_nettype wire

@@ rtl/mtg_table.sv @@
// 624-word state table: one write port, one read port, registered read data
// depends on mtg_pkg
`default_nettype none

module mtg_table (
  input  wire logic             clk,
  input  wire mtg_pkg::ram_req_t req,
  output mtg_pkg::word_t        rdata
);

  mtg_pkg::word_t mem [mtg_pkg::TBL_LEN];
  mtg_pkg::word_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ rtl/mtg_temper.sv @@
// mt19937 output tempering transform
// depends on mtg_pkg
`default_nettype none

module mtg_temper (
  input  wire mtg_pkg::word_t word_in,
  output mtg_pkg::word_t      word_out
);

  mtg_pkg::word_t y1, y2, y3;

  always_comb begin
    y1       = word_in ^ (word_in >> 11);
    y2       = y1 ^ ((y1 << 7) & mtg_pkg::TEMPER_B);
    y3       = y2 ^ ((y2 << 15) & mtg_pkg::TEMPER_C);
    word_out = y3 ^ (y3 >> 18);
  end

endmodule

`default_nettype wire

@@ rtl/mersenne_twister_generator_core.sv @@
// top level of the mt19937 generator: sequencer, fill multiplier and twist unit
// depends on mtg_pkg, mtg_table, mtg_temper and the assertion macro header
`default_nettype none

// Each input beat asks for one tempered 32-bit MT19937 word and yields exactly
// one output beat. The 624-word state is held in a single-read, single-write
// table, and one shared twist datapath plus one 32x17 fill multiplier work on
// it word by word under a small sequencer; the block takes one request at a
// time. A plain draw goes through accept, table read, then temper and load.
// When the reseed bit is set, or on the first draw after reset, the table is
// first refilled from the seed register (seed with its low bit forced to one,
// then x * 69069 per word), one table write per cycle. Every 624th draw (and
// every draw that follows a refill) the whole table is twisted first: each
// word needs two reads from the one read port. The table needs no clearing
// pass after reset since it is always filled before it is read. The finished
// word sits in an output register until taken; the next request is accepted
// meanwhile, and its result waits at the end of its work for that register
// to empty. The seed register may only be written while no request is in
// flight.
module mersenne_twister_generator_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // config
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,   // [31:0] seed_value
  // request stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [0] reseed, [7:1] zero fill
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata    // [31:0] random_word
);

  `include "mersenne_twister_generator_core_assert.svh"

  localparam int unsigned AW = mtg_pkg::AW;

  // address constants at the counter's width
  localparam logic [AW:0]   LEN_X   = (AW+1)'(mtg_pkg::TBL_LEN);
  localparam logic [AW:0]   MID_X   = (AW+1)'(mtg_pkg::TBL_MID);
  localparam mtg_pkg::addr_t LAST_A = AW'(mtg_pkg::TBL_LEN - 1);
  localparam mtg_pkg::addr_t ZERO_A = '0;
  localparam mtg_pkg::addr_t ONE_A  = AW'(1);

  // control state
  mtg_pkg::state_t state_r, state_nxt;
  logic            seeded_r, seeded_nxt;
  mtg_pkg::addr_t  words_left_r, words_left_nxt;
  mtg_pkg::addr_t  rd_pos_r, rd_pos_nxt;
  mtg_pkg::word_t  seed_r;
  logic            out_valid_r, out_valid_nxt;

  // datapath registers
  mtg_pkg::addr_t  idx_r, idx_nxt;
  mtg_pkg::word_t  x_r, x_nxt;
  mtg_pkg::word_t  cur_r, cur_nxt;
  mtg_pkg::word_t  nxt_r, nxt_nxt;
  mtg_pkg::word_t  out_data_r, out_data_nxt;

  mtg_pkg::ram_req_t req;
  mtg_pkg::word_t    rdata;
  mtg_pkg::word_t    tempered;

  // wrapped table addresses for the twist
  logic [AW:0]    mid_sum, nx2_sum;
  mtg_pkg::addr_t mid_addr, nx2_addr;
  mtg_pkg::word_t twist_y, twist_v;
  mtg_pkg::addr_t draw_idx;

  mtg_table u_table (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  mtg_temper u_temper (
    .word_in  (rdata),
    .word_out (tempered)
  );

  always_comb begin
    mid_sum  = {1'b0, idx_r} + MID_X;
    nx2_sum  = {1'b0, idx_r} + (AW+1)'(2);
    mid_addr = (mid_sum >= LEN_X) ? AW'(mid_sum - LEN_X) : mid_sum[AW-1:0];
    nx2_addr = (nx2_sum >= LEN_X) ? AW'(nx2_sum - LEN_X) : nx2_sum[AW-1:0];
    // one twist step: cur is t[i], nxt is t[i+1], rdata is t[i+397]
    twist_y  = (cur_r & mtg_pkg::UPPER_MASK) | (nxt_r & mtg_pkg::LOWER_MASK);
    twist_v  = rdata ^ (twist_y >> 1) ^ (nxt_r[0] ? mtg_pkg::TWIST_XOR : '0);
    // out-of-range read position wraps to the table start
    draw_idx = ({1'b0, rd_pos_r} >= LEN_X) ? ZERO_A : rd_pos_r;
  end

  assign in_tready  = (state_r == mtg_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    seeded_nxt     = seeded_r;
    words_left_nxt = words_left_r;
    rd_pos_nxt     = rd_pos_r;
    idx_nxt        = idx_r;
    x_nxt          = x_r;
    cur_nxt        = cur_r;
    nxt_nxt        = nxt_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    req            = '0;

    case (state_r)
      mtg_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tdata[0] || !seeded_r) begin
            idx_nxt   = ZERO_A;
            x_nxt     = seed_r | mtg_pkg::word_t'(1);
            state_nxt = mtg_pkg::ST_FILL;
          end else if (words_left_r == ZERO_A) begin
            state_nxt = mtg_pkg::ST_TW_START;
          end else begin
            idx_nxt        = draw_idx;
            rd_pos_nxt     = draw_idx + ONE_A;
            words_left_nxt = words_left_r - ONE_A;
            state_nxt      = mtg_pkg::ST_DRAW_RD;
          end
        end
      end

      // one table word per cycle from the multiplier recurrence
      mtg_pkg::ST_FILL: begin
        req.we    = 1'b1;
        req.waddr = idx_r;
        req.wdata = x_r;
        x_nxt     = mtg_pkg::word_t'(x_r * mtg_pkg::FILL_MULT);
        if (idx_r == LAST_A) begin
          seeded_nxt     = 1'b1;
          words_left_nxt = ZERO_A;
          rd_pos_nxt     = ZERO_A;
          state_nxt      = mtg_pkg::ST_TW_START;
        end else begin
          idx_nxt = idx_r + ONE_A;
        end
      end

      mtg_pkg::ST_TW_START: begin
        req.re    = 1'b1;
        req.raddr = ZERO_A;
        state_nxt = mtg_pkg::ST_TW_C0;
      end

      mtg_pkg::ST_TW_C0: begin
        cur_nxt   = rdata;
        req.re    = 1'b1;
        req.raddr = ONE_A;
        idx_nxt   = ZERO_A;
        state_nxt = mtg_pkg::ST_TW_RM;
      end

      mtg_pkg::ST_TW_RM: begin
        nxt_nxt   = rdata;
        req.re    = 1'b1;
        req.raddr = mid_addr;
        state_nxt = mtg_pkg::ST_TW_WR;
      end

      mtg_pkg::ST_TW_WR: begin
        req.we    = 1'b1;
        req.waddr = idx_r;
        req.wdata = twist_v;
        cur_nxt   = nxt_r;
        if (idx_r == LAST_A) begin
          words_left_nxt = LAST_A;
          rd_pos_nxt     = ONE_A;
          idx_nxt        = ZERO_A;
          state_nxt      = mtg_pkg::ST_DRAW_RD;
        end else begin
          // prefetch t[i+2], the next step's neighbor word
          req.re    = 1'b1;
          req.raddr = nx2_addr;
          idx_nxt   = idx_r + ONE_A;
          state_nxt = mtg_pkg::ST_TW_RM;
        end
      end

      mtg_pkg::ST_DRAW_RD: begin
        req.re    = 1'b1;
        req.raddr = idx_r;
        state_nxt = mtg_pkg::ST_DRAW_LAT;
      end

      // hold here until the output register is free
      mtg_pkg::ST_DRAW_LAT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = tempered;
          state_nxt     = mtg_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = mtg_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mtg_pkg::ST_IDLE;
      seeded_r     <= 1'b0;
      words_left_r <= '0;
      rd_pos_r     <= '0;
      seed_r       <= mtg_pkg::SEED_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      seeded_r     <= seeded_nxt;
      words_left_r <= words_left_nxt;
      rd_pos_r     <= rd_pos_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        seed_r <= cfg_wdata;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    x_r        <= x_nxt;
    cur_r      <= cur_nxt;
    nxt_r      <= nxt_nxt;
    out_data_r <= out_data_nxt;
  end

  // table writes only come from the fill and the twist write step
  `MTG_ASSERT_NOW(a_write_src, req.we, (state_r == mtg_pkg::ST_FILL) || (state_r == mtg_pkg::ST_TW_WR), "table write outside fill or twist")
  // a finished fill always goes straight into a twist
  `MTG_ASSERT_NEXT(a_fill_twist, (state_r == mtg_pkg::ST_FILL) && (idx_r == LAST_A), (state_r == mtg_pkg::ST_TW_START) && (words_left_r == ZERO_A) && seeded_r, "fill did not lead into a twist")
  // words left never reaches the table length
  `MTG_ASSERT_NOW(a_words_left, 1'b1, {1'b0, words_left_r} < LEN_X, "words left out of range")
  // a new beat only appears after the latch step
  `MTG_ASSERT_NOW(a_out_src, $rose(out_valid_r), $past(state_r == mtg_pkg::ST_DRAW_LAT), "output loaded outside latch step")

endmodule

`default_nettype wire

@@ tb/mersenne_twister_generator_core_test.sv @@
// self-checking testbench for the mt19937 generator core: request beats in, tempered words out
// depends on mtg_pkg and the mersenne_twister_generator_core rtl; needs no files or arguments
module mersenne_twister_generator_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  // request flag values carried in in_tdata[0]
  localparam bit DRAW_PLAIN  = 1'b0;
  localparam bit DRAW_RESEED = 1'b1;

  // idle profiles, applied in this order over the run
  localparam int SEND_IDLE_PCT [3] = '{13, 70, 0};
  localparam int RECV_IDLE_PCT [3] = '{70, 13, 0};

  // a fill plus a twist fits well inside this stall limit, leaving a wide margin
  localparam int STALL_LIMIT = 10000;
  localparam int QUIET_CYCLES = 10;
  localparam int MAX_PRINTED_ERRORS = 50;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [31:0] cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;   // [0] reseed, [7:1] zero fill
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // [31:0] random_word

  mersenne_twister_generator_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // ---------------------------------------------------------------------------
  // generator state mirror: seed register, 624-word table, read pointer,
  // remaining-word count and seeded flag
  // ---------------------------------------------------------------------------
  mtg_pkg::word_t seed_reg = mtg_pkg::SEED_RESET;
  mtg_pkg::word_t state_words [mtg_pkg::TBL_LEN];
  bit [9:0]       words_left = '0;
  bit [9:0]       read_pos   = '0;
  bit             seeded     = 1'b0;

  // bookkeeping
  bit             pending_reseed [$];   // request beats waiting to go out
  mtg_pkg::word_t expected_words [$];   // words predicted for accepted requests
  int    idle_mode      = 0;
  int    error_count    = 0;
  int    beats_sent     = 0;
  int    reseeds_sent   = 0;
  int    words_checked  = 0;
  int    seed_writes    = 0;
  int    twists_seen    = 0;
  int    stall_cycles   = 0;

  // fill uses the old 69069 recurrence, low seed bit forced high
  function automatic void refill_from_seed();
    mtg_pkg::word_t x;
    x = seed_reg | 32'd1;
    for (int i = 0; i < mtg_pkg::TBL_LEN; i++) begin
      state_words[i] = x;
      x = x * mtg_pkg::FILL_MULT;
    end
    words_left = '0;
    read_pos   = '0;
    seeded     = 1'b1;
  endfunction

  // in-place twist: later words see already-updated early words on wraparound
  function automatic void twist_all_words();
    mtg_pkg::word_t nxt, y, v;
    for (int i = 0; i < mtg_pkg::TBL_LEN; i++) begin
      nxt = state_words[(i + 1) % mtg_pkg::TBL_LEN];
      y   = (state_words[i] & mtg_pkg::UPPER_MASK) | (nxt & mtg_pkg::LOWER_MASK);
      v   = state_words[(i + mtg_pkg::TBL_MID) % mtg_pkg::TBL_LEN] ^ (y >> 1);
      if (nxt[0]) begin
        v = v ^ mtg_pkg::TWIST_XOR;
      end
      state_words[i] = v;
    end
    twists_seen++;
  endfunction

  function automatic mtg_pkg::word_t temper_word(input mtg_pkg::word_t raw);
    mtg_pkg::word_t y;
    y = raw;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & mtg_pkg::TEMPER_B);
    y = y ^ ((y << 15) & mtg_pkg::TEMPER_C);
    return y ^ (y >> 18);
  endfunction

  // advances the mirror by one request and returns the word it must produce
  function automatic mtg_pkg::word_t next_random_word(input bit reseed);
    mtg_pkg::word_t raw;
    bit [9:0]       idx;
    // an unseeded first draw seeds from the register, same as a reseed
    if (reseed || !seeded) begin
      refill_from_seed();
    end
    if (words_left == 10'd0) begin
      twist_all_words();
      words_left = 10'(mtg_pkg::TBL_LEN - 1);
      read_pos   = 10'd1;
      raw        = state_words[0];
    end else begin
      idx = read_pos;
      if (idx >= mtg_pkg::TBL_LEN) begin
        idx = '0;
      end
      raw        = state_words[idx];
      read_pos   = idx + 10'd1;
      words_left = words_left - 10'd1;
    end
    return temper_word(raw);
  endfunction

  task automatic report_mismatch(input string what);
    // cap the printout; every mismatch still counts
    if (error_count < MAX_PRINTED_ERRORS) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // request driver: holds a beat until taken, then pulls the next from the
  // pending queue unless this cycle is picked as a sender gap
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : request_driver
    bit hold;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else begin
      hold = in_tvalid && !in_tready;
      if (in_tvalid && in_tready) begin
        // predict at the accept edge; the seed register only changes while idle
        expected_words.push_back(next_random_word(in_tdata[0]));
        beats_sent++;
        if (in_tdata[0] == DRAW_RESEED) begin
          reseeds_sent++;
        end
      end
      if (!hold) begin
        if (pending_reseed.size() != 0 &&
            $urandom_range(99) >= SEND_IDLE_PCT[idle_mode]) begin
          in_tvalid <= 1'b1;
          in_tdata  <= {7'd0, pending_reseed.pop_front()};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: every accepted beat is matched against the oldest
  // prediction; out_tready drops at random per the active idle profile
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    mtg_pkg::word_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected result beat, random_word %08h", out_tdata));
        end else begin
          want = expected_words.pop_front();
          if (out_tdata !== want) begin
            report_mismatch($sformatf("word %0d random_word got %08h want %08h",
                                      words_checked, out_tdata, want));
          end
          words_checked++;
        end
      end
      out_tready <= ($urandom_range(99) >= RECV_IDLE_PCT[idle_mode]);
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: ends the run when no beat moves on either side for too long
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : stall_watchdog
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("[%0t] no beat moved for %0d cycles, %0d words outstanding",
                 $realtime, STALL_LIMIT, expected_words.size());
        $display("mersenne_twister_generator_core test failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // wait until every queued request went out and every result came back,
  // then a few quiet cycles so the core is back in idle
  task automatic wait_idle();
    while (pending_reseed.size() != 0 || in_tvalid || expected_words.size() != 0) begin
      @(posedge clk);
    end
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // seed write is only legal with nothing in flight
  task automatic write_seed(input mtg_pkg::word_t value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    seed_reg   = value;
    seed_writes++;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic queue_random_draws(input int count, input int reseed_one_in);
    for (int i = 0; i < count; i++) begin
      pending_reseed.push_back($urandom_range(reseed_one_in - 1) == 0 ? DRAW_RESEED
                                                                       : DRAW_PLAIN);
    end
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: first draws with no seed yet fall back to the reset seed
    idle_mode = 0;
    pending_reseed = '{DRAW_PLAIN, DRAW_PLAIN, DRAW_PLAIN, DRAW_RESEED, DRAW_PLAIN};

    // zero seed: forced low bit makes it seed one
    write_seed(32'h0000_0000);
    pending_reseed = '{DRAW_RESEED, DRAW_PLAIN};

    // all-ones seed, then its even neighbor which must fill identically
    write_seed(32'hFFFF_FFFF);
    pending_reseed = '{DRAW_RESEED, DRAW_PLAIN, DRAW_PLAIN};
    write_seed(32'hFFFF_FFFE);
    // a seed write alone leaves the current table in use
    pending_reseed = '{DRAW_PLAIN, DRAW_RESEED, DRAW_PLAIN};

    // back-to-back reseeds
    write_seed(32'h8000_0000);
    pending_reseed = '{DRAW_RESEED, DRAW_RESEED};

    // long unbroken run: twist after the reseed, the remaining 623 table words,
    // then the periodic twist when the table runs dry
    write_seed($urandom);
    pending_reseed.push_back(DRAW_RESEED);
    queue_random_draws(700, 100000);

    // receiver mostly ready, sender bursty; frequent reseeds
    write_seed($urandom);
    idle_mode = 1;
    queue_random_draws(120, 10);

    // no idling on either side
    write_seed($urandom);
    idle_mode = 2;
    queue_random_draws(60, 6);

    wait_idle();
    $display("covered %0d request beats (%0d reseeds), %0d seed writes, %0d table twists",
             beats_sent, reseeds_sent, seed_writes, twists_seen);
    $display("checked %0d result words, %0d mismatches", words_checked, error_count);
    if (error_count == 0) begin
      $display("mersenne_twister_generator_core test passed");
    end else begin
      $display("mersenne_twister_generator_core test failed");
    end
    $finish;
  end

endmodule
